FILE: rtl/nmea_line_framer_top_macros.svh
// assertion macros used by the framer core
`ifndef NMEA_LINE_FRAMER_TOP_MACROS_SVH
`define NMEA_LINE_FRAMER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define NLF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define NLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/nlf_pkg.sv
package nlf_pkg;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // pipeline control from the input stage to the core
    typedef struct packed {
        logic step;   // a transaction is processed at this edge
        logic adv;    // result side moves at this edge
    } t_pipe_ctl;

endpackage

FILE: rtl/nlf_bank.sv
module nlf_bank #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: rtl/nlf_core.sv
`include "nmea_line_framer_top_macros.svh"

module nlf_core #(
    parameter int LINE_SIZE = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nlf_pkg::t_pipe_ctl i_ctl,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_rx_byte,
    input  logic [6:0]         i_char_index,
    output logic [7:0]         o_read_char,
    output logic               o_line_ready,
    output logic [6:0]         o_pending_length,
    output logic [31:0]        o_bytes_received,
    output logic [31:0]        o_overflow_errors,
    output logic [31:0]        o_sentences_received,
    output logic [31:0]        o_sentences_dropped
);

    localparam int AW = $clog2(LINE_SIZE);
    localparam int CW = AW + 7;
    localparam logic [AW-1:0] FILL_LAST = AW'(LINE_SIZE - 1);

    logic [AW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_tlen, n_tlen;
    logic [AW-1:0] r_pend_len, n_pend_len;
    logic          r_slot, n_slot;
    logic          r_pend_bank, n_pend_bank;
    logic [31:0]   r_bytes, n_bytes;
    logic [31:0]   r_ovf, n_ovf;
    logic [31:0]   r_rcv, n_rcv;
    logic [31:0]   r_drop, n_drop;
    logic          r_rd_hit, r_rd_bank;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_hit;
    logic          swap;
    logic [7:0]    q0, q1;

    always_comb begin
        n_fill      = r_fill;
        n_tlen      = r_tlen;
        n_pend_len  = r_pend_len;
        n_slot      = r_slot;
        n_pend_bank = r_pend_bank;
        n_bytes     = r_bytes;
        n_ovf       = r_ovf;
        n_rcv       = r_rcv;
        n_drop      = r_drop;
        wr_en       = 1'b0;
        wr_addr     = r_fill;
        rd_hit      = 1'b0;
        swap        = 1'b0;
        if (i_ctl.step) begin
            case (nlf_pkg::t_op'(i_operation))
                nlf_pkg::OP_BYTE: begin
                    n_bytes = r_bytes + 32'd1;
                    if (i_rx_byte == nlf_pkg::CHAR_DOLLAR) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        n_fill  = AW'(1);
                        n_tlen  = AW'(1);
                    end else if (r_fill != '0 && i_rx_byte != nlf_pkg::CHAR_CR) begin
                        if (i_rx_byte == nlf_pkg::CHAR_LF) begin
                            if (r_slot) begin
                                n_drop = r_drop + 32'd1;
                            end else begin
                                // hand the assembly bank over instead of copying
                                swap        = 1'b1;
                                n_pend_bank = ~r_pend_bank;
                                n_pend_len  = r_tlen;
                                n_slot      = 1'b1;
                                n_rcv       = r_rcv + 32'd1;
                            end
                            n_fill = '0;
                            n_tlen = '0;
                        end else if (r_fill < FILL_LAST) begin
                            wr_en = 1'b1;
                            if (r_tlen == r_fill && i_rx_byte != nlf_pkg::CHAR_NUL) begin
                                n_tlen = r_fill + AW'(1);
                            end
                            n_fill = r_fill + AW'(1);
                        end else begin
                            n_fill = '0;
                            n_tlen = '0;
                            n_ovf  = r_ovf + 32'd1;
                        end
                    end
                end
                nlf_pkg::OP_READ: begin
                    rd_hit = CW'(i_char_index) < CW'(r_pend_len);
                end
                nlf_pkg::OP_RELEASE: begin
                    n_slot = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_tlen      <= '0;
            r_pend_len  <= '0;
            r_slot      <= 1'b0;
            r_pend_bank <= 1'b0;
            r_bytes     <= '0;
            r_ovf       <= '0;
            r_rcv       <= '0;
            r_drop      <= '0;
            r_rd_hit    <= 1'b0;
            r_rd_bank   <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_tlen      <= n_tlen;
            r_pend_len  <= n_pend_len;
            r_slot      <= n_slot;
            r_pend_bank <= n_pend_bank;
            r_bytes     <= n_bytes;
            r_ovf       <= n_ovf;
            r_rcv       <= n_rcv;
            r_drop      <= n_drop;
            if (i_ctl.adv) begin
                r_rd_hit  <= rd_hit;
                r_rd_bank <= r_pend_bank;
            end
        end
    end

    // assembly goes to the bank that is not pending
    nlf_bank #(.DEPTH(LINE_SIZE), .AW(AW)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (wr_en && r_pend_bank),
        .i_waddr (wr_addr),
        .i_wdata (i_rx_byte),
        .i_re    (i_ctl.adv && rd_hit && !r_pend_bank),
        .i_raddr (AW'(i_char_index)),
        .o_rdata (q0)
    );

    nlf_bank #(.DEPTH(LINE_SIZE), .AW(AW)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (wr_en && !r_pend_bank),
        .i_waddr (wr_addr),
        .i_wdata (i_rx_byte),
        .i_re    (i_ctl.adv && rd_hit && r_pend_bank),
        .i_raddr (AW'(i_char_index)),
        .o_rdata (q1)
    );

    assign o_read_char          = r_rd_hit ? (r_rd_bank ? q1 : q0) : nlf_pkg::CHAR_NUL;
    assign o_line_ready         = r_slot;
    assign o_pending_length     = 7'(r_pend_len);
    assign o_bytes_received     = r_bytes;
    assign o_overflow_errors    = r_ovf;
    assign o_sentences_received = r_rcv;
    assign o_sentences_dropped  = r_drop;

    `NLF_ASSERT_IMPLY(a_len_within_fill, 1'b1, r_tlen <= r_fill, "text length beyond fill")
    `NLF_ASSERT_IMPLY(a_swap_needs_empty, swap, !r_slot, "bank swap while slot full")
    `NLF_ASSERT_NEXT(a_swap_sets_slot, swap, r_slot && r_rcv == $past(r_rcv) + 32'd1,
        "swap did not fill slot")
    `NLF_ASSERT_NEXT(a_bank_held, !swap, r_pend_bank == $past(r_pend_bank),
        "pending bank flipped without swap")

endmodule

FILE: rtl/nmea_line_framer_top.sv
// nmea line framer: one transaction accepted per cycle, sustained while the result side is not stalled
// an accepted transaction is registered at the input, then its result is registered at the output
// line hand-off swaps two byte banks, so a line feed copies no bytes
// reset (i_rst_n low, synchronous) clears counters, fill state and the slot flag
// line banks are not cleared; only written entries are ever read back
module nmea_line_framer_top #(
    parameter int LINE_SIZE = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    input  logic [6:0]  i_char_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_char,
    output logic        o_line_ready,
    output logic [6:0]  o_pending_length,
    output logic [31:0] o_bytes_received,
    output logic [31:0] o_overflow_errors,
    output logic [31:0] o_sentences_received,
    output logic [31:0] o_sentences_dropped
);

    logic       r_in_v, n_in_v;
    logic       r_out_v, n_out_v;
    logic [1:0] r_op;
    logic [7:0] r_byte;
    logic [6:0] r_idx;
    logic       adv;
    logic       accept;
    nlf_pkg::t_pipe_ctl ctl;

    // result side moves unless a result is waiting and stalled
    assign adv    = !r_out_v || !i_stall;
    assign o_stall = r_in_v && !adv;
    assign accept = i_valid && !o_stall;

    always_comb begin
        ctl.step = adv && r_in_v;
        ctl.adv  = adv;
        n_in_v   = accept ? 1'b1 : (adv ? 1'b0 : r_in_v);
        n_out_v  = adv ? r_in_v : r_out_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_byte <= i_rx_byte;
            r_idx  <= i_char_index;
        end
    end

    nlf_core #(.LINE_SIZE(LINE_SIZE)) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (ctl),
        .i_operation          (r_op),
        .i_rx_byte            (r_byte),
        .i_char_index         (r_idx),
        .o_read_char          (o_read_char),
        .o_line_ready         (o_line_ready),
        .o_pending_length     (o_pending_length),
        .o_bytes_received     (o_bytes_received),
        .o_overflow_errors    (o_overflow_errors),
        .o_sentences_received (o_sentences_received),
        .o_sentences_dropped  (o_sentences_dropped)
    );

    assign o_valid = r_out_v;

endmodule
